// ----- rtl/core/fbsc_pkg.sv -----
// fbsc_pkg: shared command codes and fixed widths for the frustum culling block
// no dependencies; imported by every module under rtl/core
package fbsc_pkg;

  localparam int FIELD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int CMD_W     = 2;
  localparam int PIDX_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BOX    = 2'd1,
    CMD_SPHERE = 2'd2
  } cmd_t;

endpackage

// ----- rtl/core/frustum_box_sphere_cull.sv -----
// frustum_box_sphere_cull: top level with plane registers, item register and result register
// uses fbsc_pkg and fbsc_plane_lane
//
// Usage: one input channel (in_valid / in_stall) carries a command with its operands.
// A load writes plane in_plane_index (normal in in_first_*, offset in in_extra) at the
// transfer edge and gives no result; indexes at or above NUM_PLANES and the unused
// command are dropped. A box or sphere test gives one result on the out_valid /
// out_stall channel: out_visible is 1 when no plane has the whole volume on its non-positive side.
// A test accepted into the item register moves on to the result register when that register is free.
// Throughput: one item per cycle while out_stall is low; the per-plane multiply and five-term sum
// lie between the item register and the result register.
// A load takes effect for any test accepted after it.
// Reset clears all planes to zero and empties both stages.
// While out_stall holds a result, one more test is taken into the item register,
// then in_stall rises until the result is transferred.
module frustum_box_sphere_cull #(
  parameter int NUM_PLANES = 6,
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fbsc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [fbsc_pkg::PIDX_W-1:0]   in_plane_index,
  input  logic signed [fbsc_pkg::FIELD_W-1:0] in_first_x,
  input  logic signed [fbsc_pkg::FIELD_W-1:0] in_first_y,
  input  logic signed [fbsc_pkg::FIELD_W-1:0] in_first_z,
  input  logic signed [fbsc_pkg::FIELD_W-1:0] in_second_x,
  input  logic signed [fbsc_pkg::FIELD_W-1:0] in_second_y,
  input  logic signed [fbsc_pkg::FIELD_W-1:0] in_second_z,
  input  logic signed [fbsc_pkg::FIELD_W-1:0] in_extra,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_visible
);
  import fbsc_pkg::*;

  logic signed [COORD_BITS-1:0] pn_x_r [NUM_PLANES];
  logic signed [COORD_BITS-1:0] pn_y_r [NUM_PLANES];
  logic signed [COORD_BITS-1:0] pn_z_r [NUM_PLANES];
  logic signed [COORD_BITS-1:0] pd_r   [NUM_PLANES];

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_box_r;
  logic signed [COORD_BITS-1:0] fx_r, fy_r, fz_r, sx_r, sy_r, sz_r, ex_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_visible_r;

  logic                         accept, out_load, is_test, is_load;
  logic [NUM_PLANES-1:0]        lane_pass;

  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_test  = (in_cmd == CMD_BOX) || (in_cmd == CMD_SPHERE);
  assign is_load  = (in_cmd == CMD_LOAD) && (int'(in_plane_index) < NUM_PLANES);
  assign out_load = !out_valid_r || !out_stall;

  // plane registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        pn_x_r[i] <= '0;
        pn_y_r[i] <= '0;
        pn_z_r[i] <= '0;
        pd_r[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (accept && is_load && (int'(in_plane_index) == i)) begin
          pn_x_r[i] <= in_first_x[COORD_BITS-1:0];
          pn_y_r[i] <= in_first_y[COORD_BITS-1:0];
          pn_z_r[i] <= in_first_z[COORD_BITS-1:0];
          pd_r[i]   <= in_extra[COORD_BITS-1:0];
        end
      end
    end
  end

  // item register
  assign s1_valid_nxt = in_stall ? s1_valid_r : (accept && is_test);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_box_r <= (in_cmd == CMD_BOX);
      fx_r     <= in_first_x[COORD_BITS-1:0];
      fy_r     <= in_first_y[COORD_BITS-1:0];
      fz_r     <= in_first_z[COORD_BITS-1:0];
      sx_r     <= in_second_x[COORD_BITS-1:0];
      sy_r     <= in_second_y[COORD_BITS-1:0];
      sz_r     <= in_second_z[COORD_BITS-1:0];
      ex_r     <= in_extra[COORD_BITS-1:0];
    end
  end

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
    fbsc_plane_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .is_box  (s1_box_r),
      .norm_x  (pn_x_r[g]),
      .norm_y  (pn_y_r[g]),
      .norm_z  (pn_z_r[g]),
      .offset  (pd_r[g]),
      .first_x (fx_r),
      .first_y (fy_r),
      .first_z (fz_r),
      .second_x(sx_r),
      .second_y(sy_r),
      .second_z(sz_r),
      .extra   (ex_r),
      .pass    (lane_pass[g])
    );
  end

  // result register
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_visible_r <= &lane_pass;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  // pending test moves to the result register when it is free
  a_test_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("pending test did not reach the result register");

  // a load into an empty pipeline never yields a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_LOAD) && !s1_valid_r && !out_valid_r) |-> ##2 !out_valid_r)
    else $error("load produced a result");

  // a blocked test keeps its kind while waiting
  a_test_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (s1_valid_r && $stable(s1_box_r)))
    else $error("blocked test lost or changed");

endmodule

// ----- rtl/core/fbsc_plane_lane.sv -----
// fbsc_plane_lane: one plane against a box or sphere, pass when the exact sum is positive
// uses fbsc_pkg for the fraction width
module fbsc_plane_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                         is_box,
  input  logic signed [COORD_BITS-1:0] norm_x,
  input  logic signed [COORD_BITS-1:0] norm_y,
  input  logic signed [COORD_BITS-1:0] norm_z,
  input  logic signed [COORD_BITS-1:0] offset,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] first_z,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  input  logic signed [COORD_BITS-1:0] second_z,
  input  logic signed [COORD_BITS-1:0] extra,
  output logic                         pass
);
  import fbsc_pkg::*;

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int ACC_W  = PROD_W + 3;

  logic signed [COORD_BITS-1:0] op_x, op_y, op_z;
  logic signed [PROD_W-1:0]     prod_x, prod_y, prod_z;
  logic signed [ACC_W-1:0]      off_term, rad_term, sum;

  // larger product picks the larger corner for a non-negative coefficient
  always_comb begin
    op_x = first_x;
    op_y = first_y;
    op_z = first_z;
    if (is_box) begin
      if (norm_x[COORD_BITS-1]) op_x = (first_x < second_x) ? first_x : second_x;
      else                      op_x = (first_x > second_x) ? first_x : second_x;
      if (norm_y[COORD_BITS-1]) op_y = (first_y < second_y) ? first_y : second_y;
      else                      op_y = (first_y > second_y) ? first_y : second_y;
      if (norm_z[COORD_BITS-1]) op_z = (first_z < second_z) ? first_z : second_z;
      else                      op_z = (first_z > second_z) ? first_z : second_z;
    end
  end

  assign prod_x = PROD_W'(op_x) * PROD_W'(norm_x);
  assign prod_y = PROD_W'(op_y) * PROD_W'(norm_y);
  assign prod_z = PROD_W'(op_z) * PROD_W'(norm_z);

  assign off_term = ACC_W'(offset) <<< FRAC_BITS;
  assign rad_term = is_box ? '0 : (ACC_W'(extra) <<< FRAC_BITS);

  assign sum = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z) + off_term + rad_term;

  assign pass = !sum[ACC_W-1] && (sum != '0);

endmodule
